@@ rtl/core/zol_pkg.sv @@
// Package with shared types, codes and defaults of the zone offset lookup block.
`timescale 1ns / 1ps

package zol_pkg;

  // Default table depths.
  localparam int unsigned TransDepthDef = 1024;
  localparam int unsigned TypeDepthDef  = 256;
  localparam int unsigned LeapDepthDef  = 64;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_QUERY    = 2'd0,
    KIND_WR_TRANS = 2'd1,
    KIND_WR_TYPE  = 2'd2,
    KIND_WR_LEAP  = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TRANS_COUNT  = 3'd0,
    CFG_TYPE_COUNT   = 3'd1,
    CFG_LEAP_COUNT   = 3'd2,
    CFG_FIXED_MODE   = 3'd3,
    CFG_FIXED_OFFSET = 3'd4
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_TRANS,
    ST_TYPE_RD,
    ST_TYPE_CHK,
    ST_OFF_CHK,
    ST_DONE
  } seq_state_e;

  // Configuration register set.
  typedef struct packed {
    logic [10:0] transition_count;
    logic [8:0]  type_count;
    logic [6:0]  leap_count;
    logic        fixed_mode;
    logic [31:0] fixed_offset;
  } cfg_t;

  // Table write request.
  typedef struct packed {
    logic        trans_we;
    logic        type_we;
    logic        leap_we;
    logic [9:0]  index;
    logic [31:0] etime;
    logic [7:0]  etype;
    logic [31:0] eoffset;
  } tbl_wr_t;

endpackage

@@ rtl/core/zol_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface zol_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         entry_index;
  logic signed [31:0] entry_time;
  logic [7:0]         entry_type;
  logic signed [31:0] entry_offset;
  logic signed [63:0] query_time;

  modport source (
    output valid, kind, entry_index, entry_time, entry_type, entry_offset, query_time,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, entry_time, entry_type, entry_offset, query_time,
    output ready
  );
endinterface

interface zol_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] leap_offset;
  logic signed [31:0] leap_second;
  logic signed [31:0] zone_offset;

  modport source (
    output valid, leap_offset, leap_second, zone_offset,
    input  ready
  );
  modport sink (
    input  valid, leap_offset, leap_second, zone_offset,
    output ready
  );
endinterface

@@ rtl/core/zol_tables.sv @@
// Transition, type offset and leap tables, one write and one registered read port each.
`timescale 1ns / 1ps

module zol_tables #(
  parameter int unsigned TRANS_DEPTH = zol_pkg::TransDepthDef,
  parameter int unsigned TYPE_DEPTH  = zol_pkg::TypeDepthDef,
  parameter int unsigned LEAP_DEPTH  = zol_pkg::LeapDepthDef,
  localparam int unsigned TransAw = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1,
  localparam int unsigned TypeAw  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1,
  localparam int unsigned LeapAw  = (LEAP_DEPTH > 1) ? $clog2(LEAP_DEPTH) : 1
) (
  input  logic                clk_i,
  input  zol_pkg::tbl_wr_t    wr_i,
  input  logic [TransAw-1:0]  trans_raddr_i,
  input  logic [TypeAw-1:0]   type_raddr_i,
  input  logic [LeapAw-1:0]   leap_raddr_i,
  output logic [31:0]         trans_time_o,
  output logic [7:0]          trans_type_o,
  output logic [31:0]         type_off_o,
  output logic [31:0]         leap_base_o,
  output logic [31:0]         leap_sum_o
);

  logic [31:0] trans_time_mem [TRANS_DEPTH];
  logic [7:0]  trans_type_mem [TRANS_DEPTH];
  logic [31:0] type_off_mem   [TYPE_DEPTH];
  logic [31:0] leap_base_mem  [LEAP_DEPTH];
  logic [31:0] leap_sum_mem   [LEAP_DEPTH];

  logic [31:0] idx_ext;
  logic        trans_in_range;
  logic        type_in_range;
  logic        leap_in_range;

  // Slots beyond a table's depth are dropped.
  assign idx_ext        = {22'd0, wr_i.index};
  assign trans_in_range = idx_ext < TRANS_DEPTH;
  assign type_in_range  = idx_ext < TYPE_DEPTH;
  assign leap_in_range  = idx_ext < LEAP_DEPTH;

  // Transition table.
  always_ff @(posedge clk_i) begin
    if (wr_i.trans_we && trans_in_range) begin
      trans_time_mem[idx_ext[TransAw-1:0]] <= wr_i.etime;
      trans_type_mem[idx_ext[TransAw-1:0]] <= wr_i.etype;
    end
    trans_time_o <= trans_time_mem[trans_raddr_i];
    trans_type_o <= trans_type_mem[trans_raddr_i];
  end

  // Type offset table.
  always_ff @(posedge clk_i) begin
    if (wr_i.type_we && type_in_range) begin
      type_off_mem[idx_ext[TypeAw-1:0]] <= wr_i.eoffset;
    end
    type_off_o <= type_off_mem[type_raddr_i];
  end

  // Leap table.
  always_ff @(posedge clk_i) begin
    if (wr_i.leap_we && leap_in_range) begin
      leap_base_mem[idx_ext[LeapAw-1:0]] <= wr_i.etime;
      leap_sum_mem[idx_ext[LeapAw-1:0]]  <= wr_i.eoffset;
    end
    leap_base_o <= leap_base_mem[leap_raddr_i];
    leap_sum_o  <= leap_sum_mem[leap_raddr_i];
  end

endmodule

@@ rtl/core/zol_cmp.sv @@
// Shared signed compare of a 32-bit table time against the 64-bit query time.
`timescale 1ns / 1ps

module zol_cmp (
  input  logic [31:0] entry_i,
  input  logic [63:0] key_i,
  output logic        lt_o,
  output logic        eq_o
);

  logic signed [63:0] entry_ext;

  // Sign-extend the table time, then compare as signed 64-bit values.
  assign entry_ext = $signed({{32{entry_i[31]}}, entry_i});
  assign lt_o      = entry_ext < $signed(key_i);
  assign eq_o      = entry_ext == $signed(key_i);

endmodule

@@ rtl/core/zol_seq.sv @@
// Query sequencer: scans the leap and transition tables through the shared compare.
`timescale 1ns / 1ps

module zol_seq #(
  parameter int unsigned TRANS_DEPTH = zol_pkg::TransDepthDef,
  parameter int unsigned TYPE_DEPTH  = zol_pkg::TypeDepthDef,
  parameter int unsigned LEAP_DEPTH  = zol_pkg::LeapDepthDef,
  localparam int unsigned TransAw  = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1,
  localparam int unsigned TypeAw   = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1,
  localparam int unsigned LeapAw   = (LEAP_DEPTH > 1) ? $clog2(LEAP_DEPTH) : 1,
  localparam int unsigned MaxDepth = (TRANS_DEPTH > LEAP_DEPTH) ? TRANS_DEPTH : LEAP_DEPTH,
  localparam int unsigned CntW     = $clog2(MaxDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         query_time_i,
  input  zol_pkg::cfg_t       cfg_i,
  input  logic                room_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [31:0]         leap_offset_o,
  output logic [31:0]         leap_second_o,
  output logic [31:0]         zone_offset_o,
  output logic [TransAw-1:0]  trans_raddr_o,
  output logic [TypeAw-1:0]   type_raddr_o,
  output logic [LeapAw-1:0]   leap_raddr_o,
  input  logic [31:0]         trans_time_i,
  input  logic [7:0]          trans_type_i,
  input  logic [31:0]         type_off_i,
  input  logic [31:0]         leap_base_i,
  input  logic [31:0]         leap_sum_i
);

  zol_pkg::seq_state_e state_q, state_d;

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [TransAw-1:0] sel_q, sel_d;
  logic [63:0]        qtime_q, qtime_d;
  logic [31:0]        lo_q, lo_d;
  logic [31:0]        ls_q, ls_d;
  logic [31:0]        zo_q, zo_d;

  logic [31:0]   leap_cnt32;
  logic [31:0]   trans_cnt32;
  logic [31:0]   type_cnt32;
  logic [CntW-1:0] leap_n;
  logic [CntW-1:0] trans_n;
  logic [31:0]   type_n;
  logic          leap_end;
  logic          trans_end;
  logic [CntW-1:0] cnt_m1;
  logic [31:0]   cmp_entry;
  logic          cmp_lt;
  logic          cmp_eq;
  logic          hit_eq;
  logic          hit_ge;
  logic [7:0]    tt_val;
  logic          tt_ok;

  // Counts saturate at the table depths.
  assign leap_cnt32  = {25'd0, cfg_i.leap_count};
  assign trans_cnt32 = {21'd0, cfg_i.transition_count};
  assign type_cnt32  = {23'd0, cfg_i.type_count};
  assign leap_n  = (leap_cnt32 > LEAP_DEPTH) ? CntW'(LEAP_DEPTH) : leap_cnt32[CntW-1:0];
  assign trans_n = (trans_cnt32 > TRANS_DEPTH) ? CntW'(TRANS_DEPTH) : trans_cnt32[CntW-1:0];
  assign type_n  = (type_cnt32 > TYPE_DEPTH) ? TYPE_DEPTH : type_cnt32;

  assign leap_end  = cnt_q >= leap_n;
  assign trans_end = cnt_q >= trans_n;
  assign cnt_m1    = cnt_q - CntW'(1);

  // One compare unit serves both scans.
  assign cmp_entry = (state_q == zol_pkg::ST_TRANS) ? trans_time_i : leap_base_i;

  zol_cmp u_cmp (
    .entry_i (cmp_entry),
    .key_i   (qtime_q),
    .lt_o    (cmp_lt),
    .eq_o    (cmp_eq)
  );

  // Read data of the entry issued last cycle is checked while the next one is read.
  assign hit_eq = pend_q && cmp_eq;
  assign hit_ge = pend_q && !cmp_lt;

  // Type of the selected transition; no transitions means type 0.
  assign tt_val = (trans_n == '0) ? 8'd0 : trans_type_i;
  assign tt_ok  = {24'd0, tt_val} < type_n;

  // Table read addresses.
  assign leap_raddr_o  = cnt_q[LeapAw-1:0];
  assign trans_raddr_o = (state_q == zol_pkg::ST_TRANS) ? cnt_q[TransAw-1:0] : sel_q;
  assign type_raddr_o  = tt_val[TypeAw-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zol_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = zol_pkg::ST_LEAP;
        end
      end
      zol_pkg::ST_LEAP: begin
        if (leap_end || hit_eq) begin
          state_d = cfg_i.fixed_mode ? zol_pkg::ST_DONE : zol_pkg::ST_TRANS;
        end
      end
      zol_pkg::ST_TRANS: begin
        if (trans_end || hit_ge) begin
          state_d = zol_pkg::ST_TYPE_RD;
        end
      end
      zol_pkg::ST_TYPE_RD: begin
        state_d = zol_pkg::ST_TYPE_CHK;
      end
      zol_pkg::ST_TYPE_CHK: begin
        state_d = tt_ok ? zol_pkg::ST_OFF_CHK : zol_pkg::ST_DONE;
      end
      zol_pkg::ST_OFF_CHK: begin
        state_d = zol_pkg::ST_DONE;
      end
      zol_pkg::ST_DONE: begin
        if (room_i) begin
          state_d = zol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = zol_pkg::ST_IDLE;
      end
    endcase
  end

  // Scan counters and result updates.
  always_comb begin
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    sel_d   = sel_q;
    qtime_d = qtime_q;
    lo_d    = lo_q;
    ls_d    = ls_q;
    zo_d    = zo_q;
    unique case (state_q)
      zol_pkg::ST_IDLE: begin
        if (start_i) begin
          qtime_d = query_time_i;
          cnt_d   = '0;
          pend_d  = 1'b0;
          sel_d   = '0;
          lo_d    = '0;
          ls_d    = '0;
          zo_d    = '0;
        end
      end
      zol_pkg::ST_LEAP: begin
        if (pend_q && cmp_lt) begin
          lo_d = leap_sum_i;
        end
        if (hit_eq) begin
          ls_d = leap_sum_i - lo_q;
        end
        cnt_d  = leap_end ? cnt_q : cnt_q + CntW'(1);
        pend_d = !leap_end;
        if (leap_end || hit_eq) begin
          cnt_d  = '0;
          pend_d = 1'b0;
          if (cfg_i.fixed_mode) begin
            zo_d = cfg_i.fixed_offset;
          end
        end
      end
      zol_pkg::ST_TRANS: begin
        // Remember the last transition still before the timestamp.
        if (pend_q && cmp_lt) begin
          sel_d = cnt_m1[TransAw-1:0];
        end
        cnt_d  = trans_end ? cnt_q : cnt_q + CntW'(1);
        pend_d = !trans_end;
        if (trans_end || hit_ge) begin
          cnt_d  = '0;
          pend_d = 1'b0;
        end
      end
      zol_pkg::ST_OFF_CHK: begin
        zo_d = type_off_i;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zol_pkg::ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sel_q   <= sel_d;
    qtime_q <= qtime_d;
    lo_q    <= lo_d;
    ls_q    <= ls_d;
    zo_q    <= zo_d;
  end

  assign busy_o        = state_q != zol_pkg::ST_IDLE;
  assign done_o        = (state_q == zol_pkg::ST_DONE) && room_i;
  assign leap_offset_o = lo_q;
  assign leap_second_o = ls_q;
  assign zone_offset_o = zo_q;

endmodule

@@ rtl/core/zone_offset_lookup.sv @@
// Top level of the time-zone offset lookup: configuration, channels and result register.
`timescale 1ns / 1ps

// Write items (transition, type offset, leap entry) are written when taken. A query
// item reads the leap table and then the transition table one entry per cycle through a
// single read port per table and one shared 64-bit compare; in fixed mode it skips the
// transition scan. An equal leap base or the first transition at or after the timestamp
// ends its scan early. The block takes no new item while a query is in progress. The
// result register lets the next item be accepted while the last result is still
// waiting to be taken. Tables come up undefined after reset and must be written before
// queries read them; counts above a table's depth act as the depth.
module zone_offset_lookup #(
  parameter int unsigned TRANS_DEPTH = zol_pkg::TransDepthDef,
  parameter int unsigned TYPE_DEPTH  = zol_pkg::TypeDepthDef,
  parameter int unsigned LEAP_DEPTH  = zol_pkg::LeapDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [zol_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [zol_pkg::CfgDataW-1:0]  cfg_wdata_i,
  zol_in_if.sink                        in_if,
  zol_out_if.source                     out_if
);

  localparam int unsigned TransAw = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
  localparam int unsigned TypeAw  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
  localparam int unsigned LeapAw  = (LEAP_DEPTH > 1) ? $clog2(LEAP_DEPTH) : 1;

  zol_pkg::cfg_t    cfg_q;
  zol_pkg::tbl_wr_t tbl_wr;

  logic               in_accept;
  logic               start;
  logic               seq_busy;
  logic               seq_done;
  logic               room;
  logic [31:0]        seq_lo;
  logic [31:0]        seq_ls;
  logic [31:0]        seq_zo;
  logic [TransAw-1:0] trans_raddr;
  logic [TypeAw-1:0]  type_raddr;
  logic [LeapAw-1:0]  leap_raddr;
  logic [31:0]        trans_time;
  logic [7:0]         trans_type;
  logic [31:0]        type_off;
  logic [31:0]        leap_base;
  logic [31:0]        leap_sum;

  logic        out_valid_q;
  logic [31:0] out_lo_q;
  logic [31:0] out_ls_q;
  logic [31:0] out_zo_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (zol_pkg::cfg_idx_e'(cfg_index_i))
        zol_pkg::CFG_TRANS_COUNT:  cfg_q.transition_count <= cfg_wdata_i[10:0];
        zol_pkg::CFG_TYPE_COUNT:   cfg_q.type_count       <= cfg_wdata_i[8:0];
        zol_pkg::CFG_LEAP_COUNT:   cfg_q.leap_count       <= cfg_wdata_i[6:0];
        zol_pkg::CFG_FIXED_MODE:   cfg_q.fixed_mode       <= cfg_wdata_i[0];
        zol_pkg::CFG_FIXED_OFFSET: cfg_q.fixed_offset     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input handshake and item decode.
  assign in_if.ready = !seq_busy;
  assign in_accept   = in_if.valid && in_if.ready;
  assign start       = in_accept && (in_if.kind == zol_pkg::KIND_QUERY);

  assign tbl_wr.trans_we = in_accept && (in_if.kind == zol_pkg::KIND_WR_TRANS);
  assign tbl_wr.type_we  = in_accept && (in_if.kind == zol_pkg::KIND_WR_TYPE);
  assign tbl_wr.leap_we  = in_accept && (in_if.kind == zol_pkg::KIND_WR_LEAP);
  assign tbl_wr.index    = in_if.entry_index;
  assign tbl_wr.etime    = in_if.entry_time;
  assign tbl_wr.etype    = in_if.entry_type;
  assign tbl_wr.eoffset  = in_if.entry_offset;

  zol_tables #(
    .TRANS_DEPTH (TRANS_DEPTH),
    .TYPE_DEPTH  (TYPE_DEPTH),
    .LEAP_DEPTH  (LEAP_DEPTH)
  ) u_tables (
    .clk_i         (clk_i),
    .wr_i          (tbl_wr),
    .trans_raddr_i (trans_raddr),
    .type_raddr_i  (type_raddr),
    .leap_raddr_i  (leap_raddr),
    .trans_time_o  (trans_time),
    .trans_type_o  (trans_type),
    .type_off_o    (type_off),
    .leap_base_o   (leap_base),
    .leap_sum_o    (leap_sum)
  );

  zol_seq #(
    .TRANS_DEPTH (TRANS_DEPTH),
    .TYPE_DEPTH  (TYPE_DEPTH),
    .LEAP_DEPTH  (LEAP_DEPTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .query_time_i  (in_if.query_time),
    .cfg_i         (cfg_q),
    .room_i        (room),
    .busy_o        (seq_busy),
    .done_o        (seq_done),
    .leap_offset_o (seq_lo),
    .leap_second_o (seq_ls),
    .zone_offset_o (seq_zo),
    .trans_raddr_o (trans_raddr),
    .type_raddr_o  (type_raddr),
    .leap_raddr_o  (leap_raddr),
    .trans_time_i  (trans_time),
    .trans_type_i  (trans_type),
    .type_off_i    (type_off),
    .leap_base_i   (leap_base),
    .leap_sum_i    (leap_sum)
  );

  // Result register: a finished query loads it once the previous item is taken.
  assign room = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_lo_q <= seq_lo;
      out_ls_q <= seq_ls;
      out_zo_q <= seq_zo;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.leap_offset = out_lo_q;
  assign out_if.leap_second = out_ls_q;
  assign out_if.zone_offset = out_zo_q;

  // A query starts the sequencer on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> seq_busy)
    else $error("query accepted but sequencer not busy");

  // A write item leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !start) |=> !seq_busy)
    else $error("write item left the sequencer busy");

  // A finished query never overwrites a result still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten");

  // Results only appear after a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> $past(seq_busy))
    else $error("result without a query in progress");

endmodule

@@ sim/zone_offset_lookup_tb.sv @@
// Self-checking testbench of the zone offset lookup block with its own offset predictor.
`timescale 1ns / 1ps

module zone_offset_lookup_tb;

  localparam int unsigned TransDepth    = zol_pkg::TransDepthDef;
  localparam int unsigned TypeDepth     = zol_pkg::TypeDepthDef;
  localparam int unsigned LeapDepth     = zol_pkg::LeapDepthDef;
  localparam int unsigned RandomItems   = 550;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainCycles   = 1100;
  localparam int unsigned WatchdogLimit = 20000;

  // One input item as the testbench builds it.
  typedef struct packed {
    zol_pkg::kind_e kind;
    logic [9:0]     entry_index;
    logic [31:0]    entry_time;
    logic [7:0]     entry_type;
    logic [31:0]    entry_offset;
    logic [63:0]    query_time;
  } zone_item_t;

  // The three offsets returned for one query.
  typedef struct packed {
    logic [31:0] leap_offset;
    logic [31:0] leap_second;
    logic [31:0] zone_offset;
  } zone_offsets_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we;
  logic [zol_pkg::CfgIdxW-1:0]  cfg_index;
  logic [zol_pkg::CfgDataW-1:0] cfg_wdata;

  zol_in_if  in_ch ();
  zol_out_if out_ch ();

  zone_offset_lookup DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Shadow copy of the tables and registers.
  logic [31:0]   trans_times  [TransDepth];
  logic [7:0]    trans_types  [TransDepth];
  logic [31:0]   type_offsets [TypeDepth];
  logic [31:0]   leap_bases   [LeapDepth];
  logic [31:0]   leap_sums    [LeapDepth];
  zol_pkg::cfg_t zone_cfg;

  zone_offsets_t offsets_due [$];
  int unsigned   error_count;
  int unsigned   sender_idle_pct;
  int unsigned   receiver_stall_pct;
  int unsigned   random_items;

  always #6 clk_i = ~clk_i;

  function automatic logic signed [63:0] widen(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic int unsigned clamp(input int unsigned count, input int unsigned depth);
    return (count > depth) ? depth : count;
  endfunction

  // Offsets that a query at the given timestamp must return.
  function automatic zone_offsets_t lookup_offsets(input logic signed [63:0] stamp);
    zone_offsets_t res;
    int unsigned   n_leap;
    int unsigned   n_trans;
    int unsigned   n_type;
    int unsigned   first_after;
    int unsigned   sel;
    int unsigned   tt;
    int unsigned   i;
    bit            hit;
    res = '0;
    hit = 1'b0;
    // Leap scan stops at a base equal to the timestamp.
    n_leap = clamp(zone_cfg.leap_count, LeapDepth);
    for (i = 0; i < n_leap; i++) begin
      if (!hit) begin
        if (widen(leap_bases[i]) < stamp) begin
          res.leap_offset = leap_sums[i];
        end else if (widen(leap_bases[i]) == stamp) begin
          res.leap_second = leap_sums[i] - res.leap_offset;
          hit = 1'b1;
        end
      end
    end
    if (zone_cfg.fixed_mode) begin
      res.zone_offset = zone_cfg.fixed_offset;
    end else begin
      // The transition before the first one at or after the timestamp selects the type.
      n_trans = clamp(zone_cfg.transition_count, TransDepth);
      n_type = clamp(zone_cfg.type_count, TypeDepth);
      first_after = n_trans;
      hit = 1'b0;
      for (i = 0; i < n_trans; i++) begin
        if (!hit && widen(trans_times[i]) >= stamp) begin
          first_after = i;
          hit = 1'b1;
        end
      end
      sel = (first_after > 0) ? first_after - 1 : 0;
      tt = (sel < n_trans) ? trans_types[sel] : 0;
      res.zone_offset = (tt < n_type) ? type_offsets[tt] : '0;
    end
    return res;
  endfunction

  // Table update caused by a write item; slots beyond a table's depth are dropped.
  function automatic void store_entry(input zone_item_t it);
    case (it.kind)
      zol_pkg::KIND_WR_TRANS: begin
        if (it.entry_index < TransDepth) begin
          trans_times[it.entry_index] = it.entry_time;
          trans_types[it.entry_index] = it.entry_type;
        end
      end
      zol_pkg::KIND_WR_TYPE: begin
        if (it.entry_index < TypeDepth) type_offsets[it.entry_index] = it.entry_offset;
      end
      zol_pkg::KIND_WR_LEAP: begin
        if (it.entry_index < LeapDepth) begin
          leap_bases[it.entry_index] = it.entry_time;
          leap_sums[it.entry_index] = it.entry_offset;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic zone_item_t table_write(input zol_pkg::kind_e kind,
                                             input logic [9:0] index,
                                             input logic [31:0] etime, input logic [7:0] etype,
                                             input logic [31:0] eoffset);
    zone_item_t it;
    it.kind = kind;
    it.entry_index = index;
    it.entry_time = etime;
    it.entry_type = etype;
    it.entry_offset = eoffset;
    it.query_time = {$urandom, $urandom};
    return it;
  endfunction

  // A query carries random bits in the entry fields, which it does not use.
  function automatic zone_item_t query_item(input logic [63:0] stamp);
    zone_item_t it;
    it.kind = zol_pkg::KIND_QUERY;
    it.entry_index = $urandom_range(1023);
    it.entry_time = $urandom;
    it.entry_type = $urandom_range(255);
    it.entry_offset = $urandom;
    it.query_time = stamp;
    return it;
  endfunction

  // Send one item and account for it in the shadow state once it is accepted.
  task automatic send_item(input zone_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= it.kind;
    in_ch.entry_index  <= it.entry_index;
    in_ch.entry_time   <= it.entry_time;
    in_ch.entry_type   <= it.entry_type;
    in_ch.entry_offset <= it.entry_offset;
    in_ch.query_time   <= it.query_time;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.kind == zol_pkg::KIND_QUERY) begin
      offsets_due.push_back(lookup_offsets(it.query_time));
    end else begin
      store_entry(it);
    end
  endtask

  // Stop sending, let every result come back and give a final write time to land.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (offsets_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input zol_pkg::cfg_idx_e idx,
                         input logic [zol_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Write all registers while idle; junk in the unused upper bits is optional.
  task automatic apply_config(input zol_pkg::cfg_t cfg, input bit junk);
    logic [31:0] pad;
    wait_idle();
    pad = junk ? $urandom : '0;
    put_reg(zol_pkg::CFG_TRANS_COUNT, {pad[31:11], cfg.transition_count});
    put_reg(zol_pkg::CFG_TYPE_COUNT, {pad[31:9], cfg.type_count});
    put_reg(zol_pkg::CFG_LEAP_COUNT, {pad[31:7], cfg.leap_count});
    put_reg(zol_pkg::CFG_FIXED_MODE, {pad[31:1], cfg.fixed_mode});
    put_reg(zol_pkg::CFG_FIXED_OFFSET, cfg.fixed_offset);
    cfg_we <= 1'b0;
    zone_cfg = cfg;
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
      default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
    endcase
  endtask

  // Timestamp near a loaded transition or leap base, or anywhere in the 64-bit range.
  function automatic logic [63:0] pick_stamp(input int unsigned n_trans,
                                             input int unsigned n_leaps);
    logic signed [63:0] stamp;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 40 && n_trans > 0) begin
      stamp = widen(trans_times[$urandom_range(n_trans - 1)]) + $urandom_range(2) - 1;
    end else if (pick < 65 && n_leaps > 0) begin
      stamp = widen(leap_bases[$urandom_range(n_leaps - 1)]) + $urandom_range(2) - 1;
    end else if (pick < 80) begin
      stamp = {$urandom, $urandom};
    end else if (pick < 90) begin
      stamp = widen($urandom);
    end else begin
      case ($urandom_range(3))
        0: stamp = 64'h8000_0000_0000_0000;
        1: stamp = 64'h7FFF_FFFF_FFFF_FFFF;
        2: stamp = 64'hFFFF_FFFF_7FFF_FFFF;
        default: stamp = 64'h0000_0000_8000_0000;
      endcase
    end
    return stamp;
  endfunction

  // Fill every table slot once with ascending times, then try slots past the depths.
  task automatic load_tables();
    int unsigned i;
    for (i = 0; i < TransDepth; i++) begin
      send_item(table_write(zol_pkg::KIND_WR_TRANS, i,
                            32'h8000_0000 + (i << 22) + $urandom_range(4194303),
                            $urandom_range(255), $urandom));
    end
    for (i = 0; i < TypeDepth; i++) begin
      send_item(table_write(zol_pkg::KIND_WR_TYPE, i, $urandom, $urandom_range(255),
                            $urandom));
    end
    for (i = 0; i < LeapDepth; i++) begin
      send_item(table_write(zol_pkg::KIND_WR_LEAP, i,
                            32'h8000_0000 + (i << 26) + $urandom_range(67108863),
                            $urandom_range(255), i + $urandom_range(3)));
    end
    send_item(table_write(zol_pkg::KIND_WR_TYPE, $urandom_range(1023, TypeDepth), $urandom,
                          $urandom_range(255), $urandom));
    send_item(table_write(zol_pkg::KIND_WR_LEAP, $urandom_range(1023, LeapDepth), $urandom,
                          $urandom_range(255), $urandom));
  endtask

  // Queries against the register values that reset leaves.
  task automatic test_reset_config();
    send_item(query_item(64'h8000_0000_0000_0000));
    send_item(query_item(64'h7FFF_FFFF_FFFF_FFFF));
  endtask

  // Small hand-built zone: extreme times and offsets, exact hits and counts past depth.
  task automatic test_directed();
    zol_pkg::cfg_t cfg;
    send_item(table_write(zol_pkg::KIND_WR_TRANS, 0, 32'h8000_0000, 8'd0, $urandom));
    send_item(table_write(zol_pkg::KIND_WR_TRANS, 1, 32'd0, 8'd1, $urandom));
    send_item(table_write(zol_pkg::KIND_WR_TRANS, 2, 32'd100, 8'd2, $urandom));
    send_item(table_write(zol_pkg::KIND_WR_TRANS, 3, 32'h7FFF_FFFF, 8'd255, $urandom));
    send_item(table_write(zol_pkg::KIND_WR_TYPE, 0, $urandom, 8'd0, 32'd3600));
    send_item(table_write(zol_pkg::KIND_WR_TYPE, 1, $urandom, 8'd0, 32'h8000_0000));
    send_item(table_write(zol_pkg::KIND_WR_TYPE, 2, $urandom, 8'd0, 32'h7FFF_FFFF));
    send_item(table_write(zol_pkg::KIND_WR_TYPE, 255, $urandom, 8'd0, 32'hFFFF_F1F0));
    send_item(table_write(zol_pkg::KIND_WR_TYPE, 1023, $urandom, 8'd255, $urandom));
    send_item(table_write(zol_pkg::KIND_WR_LEAP, 0, -32'sd50, 8'd0, 32'd1));
    send_item(table_write(zol_pkg::KIND_WR_LEAP, 1, 32'd0, 8'd0, 32'd2));
    send_item(table_write(zol_pkg::KIND_WR_LEAP, 2, 32'd50, 8'd0, 32'h8000_0000));
    send_item(table_write(zol_pkg::KIND_WR_LEAP, 64, $urandom, 8'd0, $urandom));
    cfg = '{transition_count: 11'd4, type_count: 9'd3, leap_count: 7'd3,
            fixed_mode: 1'b0, fixed_offset: $urandom};
    apply_config(cfg, 1'b0);
    // Before, at and between transitions, exact leap bases, and past the last transition.
    send_item(query_item(64'h8000_0000_0000_0000));
    send_item(query_item(64'hFFFF_FFFF_8000_0000));
    send_item(query_item(64'd0));
    send_item(query_item(64'd50));
    send_item(query_item(64'd101));
    send_item(query_item(64'h0000_0000_8000_0000));
    send_item(query_item(64'h7FFF_FFFF_FFFF_FFFF));
    // Counts past the table depths act as the depths.
    cfg = '{transition_count: 11'd2047, type_count: 9'd511, leap_count: 7'd127,
            fixed_mode: 1'b0, fixed_offset: 32'd0};
    apply_config(cfg, 1'b0);
    send_item(query_item(64'd0));
    // Fixed mode at both extremes of the offset.
    cfg = '{transition_count: 11'd0, type_count: 9'd0, leap_count: 7'd0,
            fixed_mode: 1'b1, fixed_offset: 32'h8000_0000};
    apply_config(cfg, 1'b0);
    send_item(query_item({$urandom, $urandom}));
    cfg.fixed_offset = 32'h7FFF_FFFF;
    apply_config(cfg, 1'b1);
    send_item(query_item(64'd50));
  endtask

  // One random zone: sorted tables, matching counts mostly, then queries with some noise.
  task automatic run_zone_phase(input int unsigned phase);
    zol_pkg::cfg_t cfg;
    longint        t;
    bit            full;
    int unsigned   n_trans;
    int unsigned   n_types;
    int unsigned   n_leaps;
    int unsigned   n_queries;
    int unsigned   i;
    logic [31:0]   sum;
    full = (phase % 5 == 3);
    n_trans = full ? TransDepth : $urandom_range(24);
    n_types = full ? TypeDepth : $urandom_range(12, 1);
    n_leaps = $urandom_range(8);
    if (!full) begin
      t = longint'($signed($urandom));
      for (i = 0; i < n_trans; i++) begin
        send_item(table_write(zol_pkg::KIND_WR_TRANS, i, t[31:0],
                              ($urandom_range(9) == 0) ? $urandom_range(255)
                                                       : $urandom_range(n_types),
                              $urandom));
        random_items++;
        t = t + (($urandom_range(7) == 0) ? 0 : $urandom_range(1 << 24, 1));
        if (t > 64'sd2147483647) t = 64'sd2147483647;
      end
      for (i = 0; i < n_types; i++) begin
        send_item(table_write(zol_pkg::KIND_WR_TYPE, i, $urandom, $urandom_range(255),
                              ($urandom_range(7) == 0) ? $urandom
                                                       : $urandom_range(100800) - 50400));
        random_items++;
      end
    end
    // Leap bases do not descend and corrections mostly move by at most one.
    t = longint'($signed($urandom));
    sum = $urandom_range(40);
    for (i = 0; i < n_leaps; i++) begin
      send_item(table_write(zol_pkg::KIND_WR_LEAP, i, t[31:0], $urandom_range(255), sum));
      random_items++;
      t = t + (($urandom_range(7) == 0) ? 0 : $urandom_range(1 << 26, 1));
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      sum = ($urandom_range(7) == 0) ? $urandom : sum + $urandom_range(2) - 1;
    end
    cfg.transition_count = ($urandom_range(7) == 0) ? $urandom_range(2047) : n_trans;
    cfg.type_count = ($urandom_range(5) == 0) ? $urandom_range(511) : n_types;
    cfg.leap_count = ($urandom_range(5) == 0) ? $urandom_range(127) : n_leaps;
    cfg.fixed_mode = ($urandom_range(4) == 0);
    cfg.fixed_offset = $urandom;
    apply_config(cfg, $urandom_range(1));
    n_queries = full ? 6 : $urandom_range(50, 30);
    for (i = 0; i < n_queries; i++) begin
      if ($urandom_range(99) < 15) begin
        send_item(table_write(zol_pkg::kind_e'($urandom_range(3, 1)), $urandom_range(1023),
                              $urandom, $urandom_range(255), $urandom));
      end else begin
        send_item(query_item(pick_stamp(clamp(cfg.transition_count, TransDepth),
                                        clamp(cfg.leap_count, LeapDepth))));
      end
      random_items++;
    end
  endtask

  // Random zones under every idling pattern in turn.
  task automatic test_random();
    int unsigned phase;
    phase = 0;
    while (random_items < RandomItems) begin
      set_idle(phase % 4);
      run_zone_phase(phase);
      phase++;
    end
    set_idle(0);
  endtask

  // Compare one accepted result item with the oldest expected offsets.
  task automatic check_result();
    zone_offsets_t got;
    zone_offsets_t want;
    got = {out_ch.leap_offset, out_ch.leap_second, out_ch.zone_offset};
    if (offsets_due.size() == 0) begin
      error_count++;
      if (error_count <= MaxReports) begin
        $display("%0t: result item with no query pending: %s %h %s %h %s %h", $time,
                 "leap_offset", got.leap_offset, "leap_second", got.leap_second,
                 "zone_offset", got.zone_offset);
      end
    end else begin
      want = offsets_due.pop_front();
      if (got.leap_offset !== want.leap_offset || got.leap_second !== want.leap_second ||
          got.zone_offset !== want.zone_offset) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t: expected leap_offset %h leap_second %h zone_offset %h", $time,
                   want.leap_offset, want.leap_second, want.zone_offset);
          $display("%0t: actual   leap_offset %h leap_second %h zone_offset %h", $time,
                   got.leap_offset, got.leap_second, got.zone_offset);
        end
      end
    end
  endtask

  // Result side: sample the handshake at the edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) check_result();
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("zone_offset_lookup_tb: FAIL");
    $finish;
  end

  initial begin
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= '0;
    in_ch.entry_index  <= '0;
    in_ch.entry_time   <= '0;
    in_ch.entry_type   <= '0;
    in_ch.entry_offset <= '0;
    in_ch.query_time   <= '0;
    zone_cfg = '0;
    error_count = 0;
    random_items = 0;
    set_idle(0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_tables();
    test_reset_config();
    test_directed();
    test_random();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && offsets_due.size() == 0) begin
      $display("zone_offset_lookup_tb: PASS");
    end else begin
      $display("zone_offset_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/zol_pkg.sv
rtl/core/zol_if.sv
rtl/core/zol_tables.sv
rtl/core/zol_cmp.sv
rtl/core/zol_seq.sv
rtl/core/zone_offset_lookup.sv
sim/zone_offset_lookup_tb.sv
